// ===== sv/ofl_pkg.sv =====
// Package: shared constants and types for the flat object linker stream block.
`timescale 1ns / 1ps
package ofl_pkg;
  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned CHUNK_BYTES_DEF = 16;
  localparam logic [31:0] BASE_RESET = 32'h0804_8000;

  localparam logic [7:0] REC_THEADR = 8'h80;
  localparam logic [7:0] REC_COMENT = 8'h88;
  localparam logic [7:0] REC_MODEND = 8'h8A;
  localparam logic [7:0] REC_LNAMES = 8'h96;
  localparam logic [7:0] REC_SEGDEF = 8'h98;
  localparam logic [7:0] REC_GRPDEF = 8'h9A;
  localparam logic [7:0] REC_FIXUPP = 8'h9D;
  localparam logic [7:0] REC_LEDATA = 8'hA0;
  localparam logic [7:0] REC_LIDATA = 8'hA2;
  localparam logic [5:0] FIX_LOC_HI = 6'h39;
  localparam logic [7:0] FIX_TARGET = 8'h14;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_RUN = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [4:0] ERR_NONE = 5'd0;
  localparam logic [4:0] ERR_LEN_ZERO = 5'd1;
  localparam logic [4:0] ERR_SHORT = 5'd2;
  localparam logic [4:0] ERR_OFFSET = 5'd3;
  localparam logic [4:0] ERR_BLK_ZERO = 5'd4;
  localparam logic [4:0] ERR_NESTED = 5'd5;
  localparam logic [4:0] ERR_BLK_SIZE = 5'd6;
  localparam logic [4:0] ERR_LONG = 5'd7;
  localparam logic [4:0] ERR_SEG = 5'd8;
  localparam logic [4:0] ERR_THREAD = 5'd9;
  localparam logic [4:0] ERR_LOC = 5'd10;
  localparam logic [4:0] ERR_TARGET = 5'd11;
  localparam logic [4:0] ERR_FRAME = 5'd12;
  localparam logic [4:0] ERR_TDATUM = 5'd13;
  localparam logic [4:0] ERR_FIX_RANGE = 5'd14;
  localparam logic [4:0] ERR_REC_TYPE = 5'd15;
  localparam logic [4:0] ERR_TOO_BIG = 5'd16;
endpackage

// ===== sv/ofl_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module ofl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/omf_flat_linker_stream.sv =====
// Top level: object record stream parser and flat image emitter.
// Usage:
//   Input channel: in_valid/in_stall with in_byte, one stream byte per item.
//   Output channel: out_valid/out_stall with kind, chunk_low, chunk_high,
//   chunk_count, run_value, run_length, finished, error_code and last.
//   APB port: register 0 (address 0) is base_address, added to each fixup.
// Flow: plain bytes are accepted back to back unless out_stall holds the
// output register. A byte that starts a flush stalls the input while each
// chunk is read byte by byte through the single read port of the data store.
// A fixup target byte stalls it for four reads, then four writes. A result
// is registered and waits in the output register while out_stall is high;
// the parser holds the next item until that register is free.
// Reset clears the parser and halts no stream; the data store is not
// cleared, so there is no clearing pass. After an error or the module end
// record, the block halts and drops every further byte without a result.
// Fields that do not apply to a result's kind are zero.
`timescale 1ns / 1ps
module omf_flat_linker_stream #(
  parameter int unsigned STORE_DEPTH = ofl_pkg::STORE_DEPTH_DEF,
  parameter int unsigned CHUNK_BYTES = ofl_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [63:0] chunk_low,
  output logic [63:0] chunk_high,
  output logic [4:0]  chunk_count,
  output logic [7:0]  run_value,
  output logic [31:0] run_length,
  output logic        finished,
  output logic [4:0]  error_code,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned CW = $clog2(CHUNK_BYTES + 1);

  localparam logic [3:0] PH_TYPE = 4'd0;
  localparam logic [3:0] PH_LEN_LO = 4'd1;
  localparam logic [3:0] PH_LEN_HI = 4'd2;
  localparam logic [3:0] PH_SKIP = 4'd3;
  localparam logic [3:0] PH_SEG = 4'd4;
  localparam logic [3:0] PH_DOFS = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6;
  localparam logic [3:0] PH_LIHEAD = 4'd7;
  localparam logic [3:0] PH_LIBLOCK = 4'd8;
  localparam logic [3:0] PH_FIX = 4'd9;
  localparam logic [3:0] PH_CHECK = 4'd10;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_FIX_RD = 3'd2;
  localparam logic [2:0] ST_FIX_WR = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [31:0] base_address;
  logic [3:0]  parse_phase;
  logic [7:0]  record_kind;
  logic [15:0] bytes_left;
  logic [2:0]  field_step;
  logic [15:0] stream_offset;
  logic [FW-1:0] data_fill;
  logic [15:0] outer_repeat, blocks_left, inner_repeat, word_assembly;
  logic [15:0] fixup_position;
  logic        halted;

  logic [2:0]  state;
  logic        ob_full;
  logic [1:0]  ob_kind;
  logic [63:0] ob_lo, ob_hi;
  logic [4:0]  ob_cnt;
  logic [7:0]  ob_rv;
  logic [31:0] ob_rl;
  logic        ob_fin, ob_last;
  logic [4:0]  ob_err;

  // pending end-of-flush status
  logic        p_fin;
  logic [4:0]  p_err;
  logic        p_any;
  // flush walker
  logic [FW-1:0] fl_pos;
  logic [CW-1:0] fl_c;
  logic          fl_rd;
  logic [127:0]  fl_acc;
  // fixup rmw
  logic [2:0]  fx_i;
  logic [31:0] fx_word;
  logic        fx_rd;
  logic        fx_last_byte;
  // run multiply stage
  logic [31:0] prod;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  ofl_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? base_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= ofl_pkg::BASE_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      base_address <= pwdata;
    end
  end

  assign out_valid = ob_full;
  assign kind = ob_kind;
  assign chunk_low = ob_lo;
  assign chunk_high = ob_hi;
  assign chunk_count = ob_cnt;
  assign run_value = ob_rv;
  assign run_length = ob_rl;
  assign finished = ob_fin;
  assign error_code = ob_err;
  assign last = ob_last;

  logic ob_free;
  assign ob_free = !ob_full || !out_stall;
  assign in_stall = (state != ST_IDLE) || !ob_free;
  logic acc;
  assign acc = in_valid && !in_stall;

  logic [15:0] wv;
  assign wv = {in_byte, word_assembly[7:0]};
  logic [FW-1:0] fl_remain;
  assign fl_remain = data_fill - fl_pos;
  logic [CW-1:0] fl_take;
  assign fl_take = (fl_remain >= FW'(CHUNK_BYTES)) ? CW'(CHUNK_BYTES)
                                                     : CW'(fl_remain);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = fixup_position[AW-1:0];
    ram_wdata = in_byte;
    ram_raddr = AW'(fl_pos + FW'(fl_c));
    if (state == ST_IDLE && acc && !halted && parse_phase == PH_DATA
        && bytes_left != 16'd0 && fixup_position < 16'(STORE_DEPTH)) begin
      ram_we = 1'b1;
    end
    if (state == ST_FIX_RD) begin
      ram_raddr = AW'(fixup_position + 16'(fx_i));
    end
    if (state == ST_FIX_WR) begin
      ram_we = 1'b1;
      ram_waddr = AW'(fixup_position + 16'(fx_i));
      ram_wdata = fx_word[8*fx_i[1:0] +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_TYPE;
      record_kind <= '0;
      bytes_left <= '0;
      field_step <= '0;
      stream_offset <= '0;
      data_fill <= '0;
      outer_repeat <= '0;
      blocks_left <= '0;
      inner_repeat <= '0;
      word_assembly <= '0;
      fixup_position <= '0;
      halted <= 1'b0;
      state <= ST_IDLE;
      ob_full <= 1'b0;
      p_fin <= 1'b0;
      p_err <= '0;
      p_any <= 1'b0;
      fl_pos <= '0;
      fl_c <= '0;
      fl_rd <= 1'b0;
      fx_i <= '0;
      fx_rd <= 1'b0;
      fx_last_byte <= 1'b0;
    end else begin
      if (ob_full && !out_stall) ob_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc && !halted) begin
            logic [4:0] err;
            logic       fin, flush, res;
            logic [15:0] v;
            err = ofl_pkg::ERR_NONE;
            fin = 1'b0;
            flush = 1'b0;
            res = 1'b0;
            v = wv;
            unique case (parse_phase)
              PH_TYPE: begin
                record_kind <= in_byte;
                parse_phase <= PH_LEN_LO;
              end
              PH_LEN_LO: begin
                word_assembly <= {8'd0, in_byte};
                parse_phase <= PH_LEN_HI;
              end
              PH_LEN_HI: begin
                if (v == 16'd0) begin
                  err = ofl_pkg::ERR_LEN_ZERO;
                end else begin
                  bytes_left <= v - 16'd1;
                  field_step <= '0;
                  priority case (record_kind)
                    ofl_pkg::REC_MODEND: begin
                      flush = 1'b1;
                      fin = 1'b1;
                    end
                    ofl_pkg::REC_COMENT, ofl_pkg::REC_GRPDEF, ofl_pkg::REC_LNAMES,
                    ofl_pkg::REC_SEGDEF, ofl_pkg::REC_THEADR:
                      parse_phase <= (v != 16'd1) ? PH_SKIP : PH_CHECK;
                    ofl_pkg::REC_LEDATA, ofl_pkg::REC_LIDATA: begin
                      flush = 1'b1;
                      if (v - 16'd1 > 16'(STORE_DEPTH)) err = ofl_pkg::ERR_TOO_BIG;
                      else parse_phase <= PH_SEG;
                    end
                    ofl_pkg::REC_FIXUPP:
                      parse_phase <= (v != 16'd1) ? PH_FIX : PH_CHECK;
                    default: err = ofl_pkg::ERR_REC_TYPE;
                  endcase
                end
              end
              PH_CHECK: begin
                if (bytes_left != 16'd0) err = ofl_pkg::ERR_LONG;
                else parse_phase <= PH_TYPE;
              end
              default: begin
                if (bytes_left == 16'd0) begin
                  err = ofl_pkg::ERR_SHORT;
                end else begin
                  logic [15:0] bl;
                  bl = bytes_left - 16'd1;
                  bytes_left <= bl;
                  unique case (parse_phase)
                    PH_SKIP: if (bl == 16'd0) parse_phase <= PH_CHECK;
                    PH_SEG: begin
                      if (in_byte != 8'd1) err = ofl_pkg::ERR_SEG;
                      else begin
                        parse_phase <= PH_DOFS;
                        field_step <= '0;
                      end
                    end
                    PH_DOFS: begin
                      if (field_step == 3'd0) begin
                        word_assembly <= {8'd0, in_byte};
                        field_step <= 3'd1;
                      end else if (v != stream_offset) begin
                        err = ofl_pkg::ERR_OFFSET;
                      end else begin
                        field_step <= '0;
                        if (record_kind == ofl_pkg::REC_LEDATA) begin
                          data_fill <= FW'(bl);
                          stream_offset <= stream_offset + bl;
                          fixup_position <= '0;
                          parse_phase <= (bl != 16'd0) ? PH_DATA : PH_CHECK;
                        end else begin
                          parse_phase <= PH_LIHEAD;
                        end
                      end
                    end
                    PH_DATA: begin
                      fixup_position <= fixup_position + 16'd1;
                      if (bl == 16'd0) parse_phase <= PH_CHECK;
                    end
                    PH_LIHEAD: begin
                      if (field_step == 3'd0 || field_step == 3'd2) begin
                        word_assembly <= {8'd0, in_byte};
                        field_step <= field_step + 3'd1;
                      end else if (field_step == 3'd1) begin
                        outer_repeat <= v;
                        field_step <= 3'd2;
                      end else begin
                        blocks_left <= v;
                        if (v == 16'd0) err = ofl_pkg::ERR_BLK_ZERO;
                        else begin
                          parse_phase <= PH_LIBLOCK;
                          field_step <= '0;
                        end
                      end
                    end
                    PH_LIBLOCK: begin
                      if (field_step == 3'd0 || field_step == 3'd2
                          || field_step == 3'd4) begin
                        word_assembly <= {8'd0, in_byte};
                        field_step <= field_step + 3'd1;
                        if (field_step == 3'd4) prod <= outer_repeat * inner_repeat;
                      end else if (field_step == 3'd1) begin
                        inner_repeat <= v;
                        field_step <= 3'd2;
                      end else if (field_step == 3'd3) begin
                        if (v != 16'd0) err = ofl_pkg::ERR_NESTED;
                        else field_step <= 3'd4;
                      end else if (word_assembly != 16'd1) begin
                        err = ofl_pkg::ERR_BLK_SIZE;
                      end else begin
                        res = 1'b1;
                        stream_offset <= stream_offset + prod[15:0];
                        blocks_left <= blocks_left - 16'd1;
                        field_step <= '0;
                        if (blocks_left == 16'd1) parse_phase <= PH_CHECK;
                      end
                    end
                    PH_FIX: begin
                      unique case (field_step)
                        3'd0: begin
                          if (!in_byte[7]) err = ofl_pkg::ERR_THREAD;
                          else begin
                            word_assembly <= {8'd0, in_byte};
                            field_step <= 3'd1;
                          end
                        end
                        3'd1: begin
                          fixup_position <= {6'd0, word_assembly[1:0], in_byte};
                          if (word_assembly[7:2] != ofl_pkg::FIX_LOC_HI)
                            err = ofl_pkg::ERR_LOC;
                          else field_step <= 3'd2;
                        end
                        3'd2: begin
                          if (in_byte != ofl_pkg::FIX_TARGET) err = ofl_pkg::ERR_TARGET;
                          else field_step <= 3'd3;
                        end
                        3'd3: begin
                          if (in_byte != 8'd1) err = ofl_pkg::ERR_FRAME;
                          else field_step <= 3'd4;
                        end
                        default: begin
                          if (in_byte != 8'd1) err = ofl_pkg::ERR_TDATUM;
                          else if ({1'b0, fixup_position} + 17'd4 > 17'(data_fill)
                                   || {1'b0, fixup_position} + 17'd4
                                      > 17'(STORE_DEPTH))
                            err = ofl_pkg::ERR_FIX_RANGE;
                          else begin
                            state <= ST_FIX_RD;
                            fx_i <= '0;
                            fx_rd <= 1'b0;
                            fx_word <= '0;
                            fx_last_byte <= (bl == 16'd0);
                            field_step <= '0;
                          end
                        end
                      endcase
                    end
                    default: parse_phase <= PH_TYPE;
                  endcase
                end
              end
            endcase
            if (err != ofl_pkg::ERR_NONE || fin) halted <= 1'b1;
            if (flush) begin
              p_fin <= fin;
              p_err <= err;
              p_any <= 1'b0;
              fl_pos <= '0;
              fl_c <= '0;
              fl_rd <= 1'b0;
              fl_acc <= '0;
              state <= ST_FLUSH;
            end else if (res || err != ofl_pkg::ERR_NONE) begin
              ob_full <= 1'b1;
              ob_kind <= res ? ofl_pkg::KIND_RUN : ofl_pkg::KIND_STATUS;
              ob_lo <= '0;
              ob_hi <= '0;
              ob_cnt <= '0;
              ob_rv <= res ? in_byte : 8'd0;
              ob_rl <= res ? prod : 32'd0;
              ob_fin <= 1'b0;
              ob_err <= err;
              ob_last <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (fl_rd) begin
            fl_acc[8*(fl_c-CW'(1)) +: 8] <= ram_rdata;
          end
          if (fl_pos >= data_fill) begin
            fl_rd <= 1'b0;
            if (fl_rd) begin
              state <= ST_FLUSH;
            end else begin
              data_fill <= '0;
              if (!p_any && (p_fin || p_err != ofl_pkg::ERR_NONE)) state <= ST_EMIT;
              else state <= ST_IDLE;
            end
          end else if (fl_c < fl_take) begin
            fl_c <= fl_c + CW'(1);
            fl_rd <= 1'b1;
          end else if (fl_rd) begin
            fl_rd <= 1'b0;
          end else if (ob_free) begin
            logic lastc;
            lastc = (fl_pos + FW'(fl_take) >= data_fill);
            ob_full <= 1'b1;
            ob_kind <= ofl_pkg::KIND_DATA;
            ob_lo <= fl_acc[63:0];
            ob_hi <= fl_acc[127:64];
            ob_cnt <= 5'(fl_take);
            ob_rv <= '0;
            ob_rl <= '0;
            ob_fin <= lastc ? p_fin : 1'b0;
            ob_err <= lastc ? p_err : ofl_pkg::ERR_NONE;
            ob_last <= lastc;
            p_any <= 1'b1;
            fl_pos <= fl_pos + FW'(fl_take);
            fl_c <= '0;
            fl_acc <= '0;
            if (lastc) begin
              data_fill <= '0;
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (ob_free) begin
            ob_full <= 1'b1;
            ob_kind <= ofl_pkg::KIND_STATUS;
            ob_lo <= '0;
            ob_hi <= '0;
            ob_cnt <= '0;
            ob_rv <= '0;
            ob_rl <= '0;
            ob_fin <= p_fin;
            ob_err <= p_err;
            ob_last <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_FIX_RD: begin
          fx_rd <= (fx_i < 3'd4);
          if (fx_rd && fx_i < 3'd4) fx_word[8*(fx_i[1:0]-2'd1) +: 8] <= ram_rdata;
          if (fx_i < 3'd4) begin
            fx_i <= fx_i + 3'd1;
          end else begin
            fx_word <= {ram_rdata, fx_word[23:0]} + base_address;
            fx_i <= '0;
            state <= ST_FIX_WR;
          end
        end
        ST_FIX_WR: begin
          if (fx_i == 3'd3) begin
            state <= ST_IDLE;
            if (fx_last_byte) parse_phase <= PH_CHECK;
          end
          fx_i <= fx_i + 3'd1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (halted && state == ST_IDLE && !ob_full) |=> !out_valid)
    else $error("result after halt");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("item accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
  a_fix_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX_WR) |-> ({1'b0, fixup_position} + 17'(fx_i) < 17'(STORE_DEPTH)))
    else $error("fixup write beyond store");
`endif
endmodule
